// ===== sv/pairwise_landmark_loss_macros.svh =====
// assertion macros for the pairwise landmark loss block
`ifndef PAIRWISE_LANDMARK_LOSS_MACROS_SVH
`define PAIRWISE_LANDMARK_LOSS_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define PLL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pll assertion failed");
// condition must never be true out of reset
`define PLL_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pll assertion failed");
`else
`define PLL_ASSERT(lbl, prop)
`define PLL_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== sv/pll_pkg.sv =====
// shared constants, types and helpers of the pairwise landmark loss block
`timescale 1ns / 1ps
`default_nettype none
package pll_pkg;

  localparam int MaxPoints   = 16;
  localparam int MinPoints   = 2;
  localparam int PointsReset = 5;
  localparam int CoordSlots  = 2 * MaxPoints;
  localparam int IdxW        = $clog2(CoordSlots);
  localparam int CountW      = $clog2(CoordSlots + 1);
  localparam int PointsW     = 5;
  localparam int CoordW      = 16;
  localparam int ErrW        = CoordW + 1;
  localparam int MulBW       = $clog2(MaxPoints) + CoordW;
  localparam int SumW        = MulBW + 1;
  localparam int QW          = 2 * CoordW + IdxW;
  localparam int ProdW       = QW + CountW + 1;
  localparam int GradW       = 22;
  localparam int LossW       = 42;
  localparam int IndexW      = 5;
  localparam int DigitW      = 4;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SQUARE,
    S_PQ_START,
    S_PQ_WAIT,
    S_SX_START,
    S_SX_WAIT,
    S_SY_START,
    S_SY_WAIT,
    S_RD,
    S_GR_START,
    S_GR_WAIT,
    S_OUT
  } pll_state_e;

  typedef struct packed {
    logic                    start;
    logic                    flush;
    logic signed [ProdW-1:0] a;
    logic [MulBW-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [ProdW-1:0] prod;
  } mul_rsp_t;

  // magnitude of an error, never the most negative code
  function automatic logic [ErrW-2:0] abs_err(logic signed [ErrW-1:0] e);
    logic signed [ErrW-1:0] n;
    n = e[ErrW-1] ? -e : e;
    return n[ErrW-2:0];
  endfunction

  // magnitude of an axis sum
  function automatic logic [MulBW-1:0] abs_sum(logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] n;
    n = s[SumW-1] ? -s : s;
    return n[MulBW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/pll_err_mem.sv =====
// error store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module pll_err_mem
  import pll_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [IdxW-1:0]        waddr_i,
  input  wire logic signed [ErrW-1:0] wdata_i,
  input  wire logic [IdxW-1:0]        raddr_i,
  output logic signed [ErrW-1:0]      rdata_o
);

  logic signed [ErrW-1:0] mem_q [CoordSlots];
  logic signed [ErrW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/pll_serial_mul.sv =====
// digit-serial multiplier, one 4-bit digit of the unsigned operand per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "pairwise_landmark_loss_macros.svh"
module pll_serial_mul
  import pll_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output mul_rsp_t      rsp_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic signed [ProdW-1:0] acc_q, acc_d;
  logic signed [ProdW-1:0] a_q, a_d;
  logic [MulBW-1:0]        b_q, b_d;
  logic [DigitW-1:0]       digit;
  logic signed [ProdW-1:0] part;
  logic [MulBW-1:0]        b_next;

  assign digit  = b_q[DigitW-1:0];
  assign part   = a_q * $signed({1'b0, digit});
  assign b_next = b_q >> DigitW;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.flush) begin
      busy_d = 1'b0;
    end else if (req_i.start) begin
      acc_d = '0;
      a_d   = req_i.a;
      b_d   = req_i.b;
      if (req_i.b == '0) begin
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      acc_d = acc_q + part;
      a_d   = a_q << DigitW;
      b_d   = b_next;
      if (b_next == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  `PLL_ASSERT_NEVER(a_busy_done, busy_q && done_q)
  `PLL_ASSERT(a_start_idle, req_i.start |-> !busy_q)
  `PLL_ASSERT_NEVER(a_busy_digits, busy_q && (b_q == '0))

endmodule
`default_nettype wire

// ===== sv/pairwise_landmark_loss.sv =====
// pairwise landmark loss: top level with sample sequencer and output register
// Takes one sample as 2*P coordinate transfers (all x values, then all y values), each a
// predicted and true Q8.8 pair, where P is points_in_use clamped to 2..16. For each axis it
// returns, per coordinate, the sum over the other points of (e_i - e_j) with e = pred - true,
// and on every result the sample loss, the sum of (e_i - e_j)^2 over all pairs of both axes.
// Internally the pairwise sums are formed as P*e_i - S and P*sum(e^2) - Sx^2 - Sy^2, all
// products running through one shared digit-serial multiplier that consumes a 4-bit digit of
// its unsigned operand per cycle. A coordinate transfer is accepted, its square is formed
// digit by digit over |e| up to its highest nonzero digit, and it is then retired.
// After the last coordinate the loss takes three multiplies of up to 2, 5 and 5 digits, then
// each result passes through an error store read, a P*e multiply and an output register load.
// The output register lets a finished result wait while the next sample starts loading.
// Writing points_in_use drops any partial sample; no coordinate is taken in that cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "pairwise_landmark_loss_macros.svh"
module pairwise_landmark_loss
  import pll_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration
  input  wire logic                     cfg_we_i,
  input  wire logic [PointsW-1:0]       cfg_wdata_i,
  // coordinate input
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic signed [CoordW-1:0] predicted_coord_i,
  input  wire logic signed [CoordW-1:0] true_coord_i,
  // gradient results
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [IndexW-1:0]             coord_index_o,
  output logic signed [GradW-1:0]       gradient_o,
  output logic [LossW-1:0]              sample_loss_o,
  output logic                          last_of_sample_o
);

  pll_state_e state_q, state_d;

  logic [PointsW-1:0]      cfg_points_q;
  logic [CountW-1:0]       load_cnt_q, load_cnt_d;
  logic [CountW-1:0]       emit_cnt_q, emit_cnt_d;
  logic signed [SumW-1:0]  sum_x_q, sum_x_d;
  logic signed [SumW-1:0]  sum_y_q, sum_y_d;
  logic [QW-1:0]           sq_acc_q, sq_acc_d;
  logic signed [ProdW-1:0] loss_q, loss_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [IndexW-1:0]       out_index_q, out_index_d;
  logic signed [GradW-1:0] out_grad_q, out_grad_d;
  logic [LossW-1:0]        out_loss_q, out_loss_d;
  logic                    out_last_q, out_last_d;

  // active point count and sample length
  logic [CountW-1:0]       p_act;
  logic [CountW-1:0]       total;
  logic [CountW-1:0]       total_m1;

  logic signed [ErrW-1:0]  err_in;
  logic [ErrW-2:0]         err_mag;
  logic                    in_x;
  logic                    emit_x;
  logic signed [SumW-1:0]  sum_sel;
  logic signed [ProdW-1:0] grad_full;
  logic [MulBW-1:0]        p_ext;

  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [IdxW-1:0]         mem_raddr;
  logic signed [ErrW-1:0]  mem_rdata;

  mul_req_t                mul_req;
  mul_rsp_t                mul_rsp;

  // clamp the register to the supported point range
  always_comb begin
    if (cfg_points_q < PointsW'(MinPoints)) begin
      p_act = CountW'(MinPoints);
    end else if (int'(cfg_points_q) > MaxPoints) begin
      p_act = CountW'(MaxPoints);
    end else begin
      p_act = CountW'(cfg_points_q);
    end
  end

  assign total    = p_act << 1;
  assign total_m1 = total - CountW'(1);
  assign p_ext    = {{(MulBW-CountW){1'b0}}, p_act};

  // error of the incoming coordinate
  assign err_in  = $signed({predicted_coord_i[CoordW-1], predicted_coord_i})
                 - $signed({true_coord_i[CoordW-1], true_coord_i});
  assign err_mag = abs_err(err_in);
  assign in_x    = load_cnt_q < p_act;

  // gradient of the coordinate being emitted: P*e_k minus its axis sum
  assign emit_x    = emit_cnt_q < p_act;
  assign sum_sel   = emit_x ? sum_x_q : sum_y_q;
  assign grad_full = mul_rsp.prod - {{(ProdW-SumW){sum_sel[SumW-1]}}, sum_sel};

  // a register write takes the cycle, so no coordinate is taken with it
  assign in_stall_o = (state_q != S_LOAD) || cfg_we_i;
  assign mem_waddr  = load_cnt_q[IdxW-1:0];
  assign mem_raddr  = emit_cnt_q[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    emit_cnt_d  = emit_cnt_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    sq_acc_d    = sq_acc_q;
    loss_d      = loss_q;
    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    out_grad_d  = out_grad_q;
    out_loss_d  = out_loss_q;
    out_last_d  = out_last_q;
    mul_req     = '0;
    mem_we      = 1'b0;

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      // new point count: drop the partial sample
      load_cnt_d    = '0;
      sum_x_d       = '0;
      sum_y_d       = '0;
      sq_acc_d      = '0;
      mul_req.flush = 1'b1;
      state_d       = S_LOAD;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (in_valid_i) begin
            mem_we     = 1'b1;
            load_cnt_d = load_cnt_q + CountW'(1);
            if (in_x) begin
              sum_x_d = sum_x_q + {{(SumW-ErrW){err_in[ErrW-1]}}, err_in};
            end else begin
              sum_y_d = sum_y_q + {{(SumW-ErrW){err_in[ErrW-1]}}, err_in};
            end
            mul_req.start = 1'b1;
            mul_req.a     = {{(ProdW-ErrW+1){1'b0}}, err_mag};
            mul_req.b     = {{(MulBW-ErrW+1){1'b0}}, err_mag};
            state_d       = S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (mul_rsp.done) begin
            sq_acc_d = sq_acc_q + mul_rsp.prod[QW-1:0];
            state_d  = (load_cnt_q == total) ? S_PQ_START : S_LOAD;
          end
        end
        S_PQ_START: begin
          mul_req.start = 1'b1;
          mul_req.a     = {{(ProdW-QW){1'b0}}, sq_acc_q};
          mul_req.b     = p_ext;
          state_d       = S_PQ_WAIT;
        end
        S_PQ_WAIT: begin
          if (mul_rsp.done) begin
            loss_d  = mul_rsp.prod;
            state_d = S_SX_START;
          end
        end
        S_SX_START: begin
          mul_req.start = 1'b1;
          mul_req.a     = {{(ProdW-MulBW){1'b0}}, abs_sum(sum_x_q)};
          mul_req.b     = abs_sum(sum_x_q);
          state_d       = S_SX_WAIT;
        end
        S_SX_WAIT: begin
          if (mul_rsp.done) begin
            loss_d  = loss_q - mul_rsp.prod;
            state_d = S_SY_START;
          end
        end
        S_SY_START: begin
          mul_req.start = 1'b1;
          mul_req.a     = {{(ProdW-MulBW){1'b0}}, abs_sum(sum_y_q)};
          mul_req.b     = abs_sum(sum_y_q);
          state_d       = S_SY_WAIT;
        end
        S_SY_WAIT: begin
          if (mul_rsp.done) begin
            loss_d     = loss_q - mul_rsp.prod;
            emit_cnt_d = '0;
            state_d    = S_RD;
          end
        end
        S_RD: begin
          // store read issued at emit_cnt_q, data next cycle
          state_d = S_GR_START;
        end
        S_GR_START: begin
          mul_req.start = 1'b1;
          mul_req.a     = {{(ProdW-ErrW){mem_rdata[ErrW-1]}}, mem_rdata};
          mul_req.b     = p_ext;
          state_d       = S_GR_WAIT;
        end
        S_GR_WAIT: begin
          if (mul_rsp.done) begin
            state_d = S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_d = 1'b1;
            out_index_d = IndexW'(emit_cnt_q);
            out_grad_d  = grad_full[GradW-1:0];
            out_loss_d  = loss_q[LossW-1:0];
            out_last_d  = (emit_cnt_q == total_m1);
            emit_cnt_d  = emit_cnt_q + CountW'(1);
            if (emit_cnt_q == total_m1) begin
              // sample done, start the next one clean
              load_cnt_d = '0;
              sum_x_d    = '0;
              sum_y_d    = '0;
              sq_acc_d   = '0;
              state_d    = S_LOAD;
            end else begin
              state_d = S_RD;
            end
          end
        end
        default: begin
          state_d = S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_points_q <= PointsW'(PointsReset);
      load_cnt_q   <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      sq_acc_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_points_q <= cfg_wdata_i;
      end
      load_cnt_q  <= load_cnt_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      sq_acc_q    <= sq_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    emit_cnt_q  <= emit_cnt_d;
    loss_q      <= loss_d;
    out_index_q <= out_index_d;
    out_grad_q  <= out_grad_d;
    out_loss_q  <= out_loss_d;
    out_last_q  <= out_last_d;
  end

  pll_err_mem u_err_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (err_in),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pll_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign out_valid_o      = out_valid_q;
  assign coord_index_o    = out_index_q;
  assign gradient_o       = out_grad_q;
  assign sample_loss_o    = out_loss_q;
  assign last_of_sample_o = out_last_q;

  `PLL_ASSERT_NEVER(a_cnt_range, load_cnt_q > total)
  `PLL_ASSERT(a_in_mul_idle, (in_valid_i && !in_stall_o) |-> !mul_rsp.busy)
  `PLL_ASSERT(a_done_wait, mul_rsp.done |-> (state_q == S_SQUARE ||
    state_q == S_PQ_WAIT || state_q == S_SX_WAIT || state_q == S_SY_WAIT ||
    state_q == S_GR_WAIT))
  `PLL_ASSERT(a_emit_range, (state_q == S_OUT) |-> (emit_cnt_q < total))

endmodule
`default_nettype wire
